>>> src/weighted_stretched_dot_product_assert.svh
// assertion macros shared by the checker
`ifndef WEIGHTED_STRETCHED_DOT_PRODUCT_ASSERT_SVH
`define WEIGHTED_STRETCHED_DOT_PRODUCT_ASSERT_SVH

// same-cycle implication, off while in reset
`define WSDP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while in reset
`define WSDP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> (cons)) else $error(msg);

// checked at every edge, reset included
`define WSDP_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

>>> src/wsdp_pkg.sv
`default_nettype none

package wsdp_pkg;

  localparam int unsigned GridDepthDef = 4096;

  localparam int unsigned VecW     = 32;
  localparam int unsigned StrW     = 16;
  localparam int unsigned ProdW    = 2 * VecW;
  localparam int unsigned DotW     = ProdW + 2;
  localparam int unsigned MagW     = 64;
  localparam int unsigned WgtW     = 6;
  localparam int unsigned NumW     = MagW + WgtW;
  localparam int unsigned FracShift = 42;
  localparam int unsigned DivSteps = NumW + FracShift;
  localparam int unsigned StrProdW = 3 * StrW;
  localparam int unsigned DenW     = StrProdW + WgtW;
  localparam int unsigned QuoW     = 64;
  localparam int unsigned SumW     = 64;

  localparam int unsigned BoundaryPts = 4;
  localparam int unsigned BndIdxW     = $clog2(BoundaryPts);
  localparam logic [WgtW-1:0] WeightDen = WgtW'(48);

  localparam logic [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned CfgIdxW   = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEPTH_LAST = 1'b0,
    CFG_BOUNDARY_EN = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUM,
    BK_ABS,
    BK_SCALE,
    BK_DIV,
    BK_ACC
  } back_state_e;

  typedef struct packed {
    logic signed [VecW-1:0] u_x;
    logic signed [VecW-1:0] u_y;
    logic signed [VecW-1:0] u_z;
    logic signed [VecW-1:0] v_x;
    logic signed [VecW-1:0] v_y;
    logic signed [VecW-1:0] v_z;
    logic [StrW-1:0]        stretch_x;
    logic [StrW-1:0]        stretch_y;
    logic [StrW-1:0]        stretch_z;
    logic [WgtW-1:0]        weight;
    logic                   last_point;
  } entry_t;

  typedef struct packed {
    logic            done;
    logic            ovf;
    logic [QuoW-1:0] quo;
  } div_res_t;

  // norm weight numerators over 48, counted from the boundary
  function automatic logic [WgtW-1:0] norm_weight(input logic [BndIdxW-1:0] idx);
    logic [WgtW-1:0] w;
    case (idx)
      2'd0:    w = WgtW'(17);
      2'd1:    w = WgtW'(59);
      2'd2:    w = WgtW'(43);
      default: w = WgtW'(49);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> src/wsdp_fifo.sv
`default_nettype none

module wsdp_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wsdp_pkg::entry_t data_i,
  input  logic             pop_i,
  output wsdp_pkg::entry_t data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (wsdp_pkg::FifoDepth > 1) ? $clog2(wsdp_pkg::FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(wsdp_pkg::FifoDepth + 1);

  wsdp_pkg::entry_t mem_q [wsdp_pkg::FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(wsdp_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(wsdp_pkg::FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(wsdp_pkg::FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/wsdp_front.sv
`default_nettype none

module wsdp_front #(
  parameter int unsigned GRID_DEPTH = wsdp_pkg::GridDepthDef,
  localparam int unsigned DepthW = $clog2(GRID_DEPTH + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [wsdp_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [DepthW-1:0]                    cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [wsdp_pkg::VecW-1:0]     u_x_i,
  input  logic signed [wsdp_pkg::VecW-1:0]     u_y_i,
  input  logic signed [wsdp_pkg::VecW-1:0]     u_z_i,
  input  logic signed [wsdp_pkg::VecW-1:0]     v_x_i,
  input  logic signed [wsdp_pkg::VecW-1:0]     v_y_i,
  input  logic signed [wsdp_pkg::VecW-1:0]     v_z_i,
  input  logic [wsdp_pkg::StrW-1:0]            stretch_x_i,
  input  logic [wsdp_pkg::StrW-1:0]            stretch_y_i,
  input  logic [wsdp_pkg::StrW-1:0]            stretch_z_i,
  input  logic [DepthW-1:0]                    depth_index_i,
  input  logic                                 last_point_i,
  input  logic                                 full_i,
  output logic                                 push_o,
  output wsdp_pkg::entry_t                     entry_o
);

  logic [DepthW-1:0] depth_last_q;
  logic [1:0]        bnd_en_q;

  logic [DepthW:0]   hi_diff;
  logic [DepthW-1:0] lo_idx;
  logic              low_hit, high_hit;
  logic [wsdp_pkg::WgtW-1:0] weight;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_last_q <= DepthW'(GRID_DEPTH);
      bnd_en_q     <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == wsdp_pkg::CFG_DEPTH_LAST) begin
        depth_last_q <= cfg_data_i;
      end else if (cfg_idx_i == wsdp_pkg::CFG_BOUNDARY_EN) begin
        bnd_en_q <= cfg_data_i[1:0];
      end
    end
  end

  // borrow out of hi_diff means the point lies past the last depth index
  always_comb begin
    hi_diff  = {1'b0, depth_last_q} - {1'b0, depth_index_i};
    lo_idx   = depth_index_i - 1'b1;
    low_hit  = bnd_en_q[0] && (depth_index_i != '0) &&
               (depth_index_i <= DepthW'(wsdp_pkg::BoundaryPts));
    high_hit = bnd_en_q[1] && !hi_diff[DepthW] &&
               (hi_diff < (DepthW + 1)'(wsdp_pkg::BoundaryPts));
    if (high_hit) begin
      weight = wsdp_pkg::norm_weight(hi_diff[wsdp_pkg::BndIdxW-1:0]);
    end else if (low_hit) begin
      weight = wsdp_pkg::norm_weight(lo_idx[wsdp_pkg::BndIdxW-1:0]);
    end else begin
      weight = wsdp_pkg::WeightDen;
    end
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    entry_o.u_x        = u_x_i;
    entry_o.u_y        = u_y_i;
    entry_o.u_z        = u_z_i;
    entry_o.v_x        = v_x_i;
    entry_o.v_y        = v_y_i;
    entry_o.v_z        = v_z_i;
    entry_o.stretch_x  = stretch_x_i;
    entry_o.stretch_y  = stretch_y_i;
    entry_o.stretch_z  = stretch_z_i;
    entry_o.weight     = weight;
    entry_o.last_point = last_point_i;
  end

endmodule

`default_nettype wire

>>> src/wsdp_div.sv
`default_nettype none

module wsdp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [wsdp_pkg::NumW-1:0]  num_i,
  input  logic [wsdp_pkg::DenW-1:0]  den_i,
  output wsdp_pkg::div_res_t         res_o
);

  localparam int unsigned CntW = $clog2(wsdp_pkg::DivSteps);

  logic [wsdp_pkg::DivSteps-1:0] shf_q;
  logic [wsdp_pkg::DenW-1:0]     den_q, rem_q;
  logic [wsdp_pkg::QuoW-1:0]     quo_q;
  logic                          ovf_q;
  logic [CntW-1:0]               cnt_q;
  logic                          busy_q, done_q;

  logic [wsdp_pkg::DenW:0]       rem_sh, rem_nx;
  logic                          fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, shf_q[wsdp_pkg::DivSteps-1]};
    fits   = (rem_sh >= {1'b0, den_q});
    rem_nx = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shf_q <= {num_i, {wsdp_pkg::FracShift{1'b0}}};
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      shf_q <= {shf_q[wsdp_pkg::DivSteps-2:0], 1'b0};
      rem_q <= rem_nx[wsdp_pkg::DenW-1:0];
      quo_q <= {quo_q[wsdp_pkg::QuoW-2:0], fits};
      // a quotient bit pushed out the top means the result is beyond 64 bits
      ovf_q <= ovf_q | quo_q[wsdp_pkg::QuoW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CntW'(wsdp_pkg::DivSteps - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_o.done = done_q;
    res_o.ovf  = ovf_q;
    res_o.quo  = quo_q;
  end

endmodule

`default_nettype wire

>>> src/wsdp_back.sv
`default_nettype none

module wsdp_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              empty_i,
  output logic                              pop_o,
  input  wsdp_pkg::entry_t                  entry_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [wsdp_pkg::SumW-1:0]  weighted_sum_o,
  output logic                              saturated_o
);

  wsdp_pkg::back_state_e state_q, state_d;
  wsdp_pkg::entry_t      ent_q;

  logic signed [wsdp_pkg::ProdW-1:0] p0_q, p1_q, p2_q;
  logic [2*wsdp_pkg::StrW-1:0]       sxy_q;
  logic signed [wsdp_pkg::DotW-1:0]  dot_q;
  logic [wsdp_pkg::StrProdW-1:0]     sxyz_q;
  logic                              neg_q;
  logic [wsdp_pkg::MagW-1:0]         mag_q;
  logic [wsdp_pkg::DenW-1:0]         den_q;
  logic [wsdp_pkg::SumW-1:0]         term_q;
  logic                              term_ovf_q;
  logic [wsdp_pkg::SumW-1:0]         sum_q;
  logic                              sum_ovf_q;
  logic                              out_valid_q;
  logic [wsdp_pkg::SumW-1:0]         out_sum_q;
  logic                              out_sat_q;

  logic [wsdp_pkg::DotW-1:0]         dot_abs;
  logic [wsdp_pkg::NumW-1:0]         num;
  logic                              mag_zero, den_zero;
  logic                              div_start, out_load, acc_go;
  wsdp_pkg::div_res_t                div_res;
  logic                              q_big;
  logic [wsdp_pkg::SumW-1:0]         term_div;
  logic [wsdp_pkg::SumW-1:0]         sum_raw, sum_sat;
  logic                              add_ovf, ovf_all;

  assign dot_abs  = dot_q[wsdp_pkg::DotW-1] ? -dot_q : dot_q;
  assign num      = wsdp_pkg::NumW'(mag_q) * wsdp_pkg::NumW'(ent_q.weight);
  assign mag_zero = (mag_q == '0);
  assign den_zero = (den_q == '0);

  wsdp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den_q),
    .res_o   (div_res)
  );

  // clamp the quotient into the signed range, sign taken from the dot product
  always_comb begin
    if (neg_q) begin
      q_big    = div_res.ovf || (div_res.quo > wsdp_pkg::SumMin);
      term_div = q_big ? wsdp_pkg::SumMin : -div_res.quo;
    end else begin
      q_big    = div_res.ovf || div_res.quo[wsdp_pkg::QuoW-1];
      term_div = q_big ? wsdp_pkg::SumMax : div_res.quo;
    end
  end

  always_comb begin
    sum_raw = sum_q + term_q;
    add_ovf = (sum_q[wsdp_pkg::SumW-1] == term_q[wsdp_pkg::SumW-1]) &&
              (sum_raw[wsdp_pkg::SumW-1] != sum_q[wsdp_pkg::SumW-1]);
    if (add_ovf) begin
      sum_sat = sum_q[wsdp_pkg::SumW-1] ? wsdp_pkg::SumMin : wsdp_pkg::SumMax;
    end else begin
      sum_sat = sum_raw;
    end
    ovf_all = sum_ovf_q | term_ovf_q | add_ovf;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wsdp_pkg::BK_IDLE:  if (!empty_i) state_d = wsdp_pkg::BK_MUL;
      wsdp_pkg::BK_MUL:   state_d = wsdp_pkg::BK_SUM;
      wsdp_pkg::BK_SUM:   state_d = wsdp_pkg::BK_ABS;
      wsdp_pkg::BK_ABS:   state_d = wsdp_pkg::BK_SCALE;
      wsdp_pkg::BK_SCALE: begin
        state_d = (mag_zero || den_zero) ? wsdp_pkg::BK_ACC : wsdp_pkg::BK_DIV;
      end
      wsdp_pkg::BK_DIV:   if (div_res.done) state_d = wsdp_pkg::BK_ACC;
      wsdp_pkg::BK_ACC:   if (acc_go) state_d = wsdp_pkg::BK_IDLE;
      default:            state_d = wsdp_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    acc_go    = 1'b0;
    case (state_q)
      wsdp_pkg::BK_IDLE:  pop_o = !empty_i;
      wsdp_pkg::BK_SCALE: div_start = !mag_zero && !den_zero;
      wsdp_pkg::BK_ACC: begin
        // a last point waits until the output register can take the sum
        out_load = ent_q.last_point && (!out_valid_q || out_ready_i);
        acc_go   = !ent_q.last_point || out_load;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= entry_i;
    end
    if (state_q == wsdp_pkg::BK_MUL) begin
      p0_q  <= ent_q.u_x * ent_q.v_x;
      p1_q  <= ent_q.u_y * ent_q.v_y;
      p2_q  <= ent_q.u_z * ent_q.v_z;
      sxy_q <= ent_q.stretch_x * ent_q.stretch_y;
    end
    if (state_q == wsdp_pkg::BK_SUM) begin
      dot_q  <= wsdp_pkg::DotW'(p0_q) + wsdp_pkg::DotW'(p1_q) + wsdp_pkg::DotW'(p2_q);
      sxyz_q <= sxy_q * ent_q.stretch_z;
    end
    if (state_q == wsdp_pkg::BK_ABS) begin
      neg_q <= dot_q[wsdp_pkg::DotW-1];
      mag_q <= dot_abs[wsdp_pkg::MagW-1:0];
      den_q <= wsdp_pkg::DenW'(sxyz_q) * wsdp_pkg::DenW'(wsdp_pkg::WeightDen);
    end
    if (state_q == wsdp_pkg::BK_SCALE && !div_start) begin
      // zero dot product gives zero; zero divisor pins to the rail
      term_q     <= mag_zero ? '0 : (neg_q ? wsdp_pkg::SumMin : wsdp_pkg::SumMax);
      term_ovf_q <= !mag_zero;
    end
    if (state_q == wsdp_pkg::BK_DIV && div_res.done) begin
      term_q     <= term_div;
      term_ovf_q <= q_big;
    end
    if (out_load) begin
      out_sum_q <= sum_sat;
      out_sat_q <= ovf_all;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wsdp_pkg::BK_IDLE;
      sum_q       <= '0;
      sum_ovf_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (acc_go) begin
        if (ent_q.last_point) begin
          sum_q     <= '0;
          sum_ovf_q <= 1'b0;
        end else begin
          sum_q     <= sum_sat;
          sum_ovf_q <= ovf_all;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign weighted_sum_o = out_sum_q;
  assign saturated_o    = out_sat_q;

endmodule

`default_nettype wire

>>> src/weighted_stretched_dot_product.sv
// result: a last point's sum is loaded into the output register after the divider step
// (which is skipped when the dot product is zero or a stretching factor is zero)
// pace: the back end works one grid point at a time; its 112-step bit-serial divider sets the pace
// a two-entry queue lets two more points transfer while one is being worked
// reset: async active low; clears sum, sticky flag, queue and output valid, depth_last
// returns to GRID_DEPTH and boundary weights to off; no clearing pass
`default_nettype none

module weighted_stretched_dot_product #(
  parameter int unsigned GRID_DEPTH = wsdp_pkg::GridDepthDef,
  localparam int unsigned DepthW = $clog2(GRID_DEPTH + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wsdp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [DepthW-1:0]                  cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [wsdp_pkg::VecW-1:0]   u_x_i,
  input  logic signed [wsdp_pkg::VecW-1:0]   u_y_i,
  input  logic signed [wsdp_pkg::VecW-1:0]   u_z_i,
  input  logic signed [wsdp_pkg::VecW-1:0]   v_x_i,
  input  logic signed [wsdp_pkg::VecW-1:0]   v_y_i,
  input  logic signed [wsdp_pkg::VecW-1:0]   v_z_i,
  input  logic [wsdp_pkg::StrW-1:0]          stretch_x_i,
  input  logic [wsdp_pkg::StrW-1:0]          stretch_y_i,
  input  logic [wsdp_pkg::StrW-1:0]          stretch_z_i,
  input  logic [DepthW-1:0]                  depth_index_i,
  input  logic                               last_point_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [wsdp_pkg::SumW-1:0]   weighted_sum_o,
  output logic                               saturated_o
);

  logic             push, pop, full, empty;
  wsdp_pkg::entry_t push_entry, head_entry;

  wsdp_front #(
    .GRID_DEPTH (GRID_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .u_x_i         (u_x_i),
    .u_y_i         (u_y_i),
    .u_z_i         (u_z_i),
    .v_x_i         (v_x_i),
    .v_y_i         (v_y_i),
    .v_z_i         (v_z_i),
    .stretch_x_i   (stretch_x_i),
    .stretch_y_i   (stretch_y_i),
    .stretch_z_i   (stretch_z_i),
    .depth_index_i (depth_index_i),
    .last_point_i  (last_point_i),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  wsdp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .pop_i   (pop),
    .data_o  (head_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  wsdp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .pop_o          (pop),
    .entry_i        (head_entry),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .weighted_sum_o (weighted_sum_o),
    .saturated_o    (saturated_o)
  );

endmodule

`default_nettype wire

>>> src/wsdp_checker.sv
`default_nettype none
`include "weighted_stretched_dot_product_assert.svh"

module wsdp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [wsdp_pkg::SumW-1:0]  weighted_sum_o,
  input logic                              saturated_o
);

  // a held result keeps its value until transferred
  `WSDP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i), out_valid_o && $stable(weighted_sum_o) && $stable(saturated_o), "stalled result changed")

  // the back end takes points more slowly than back-to-back transfers arrive, so the queue fills
  `WSDP_ASSERT_NEXT(a_queue_fills, clk_i, rst_ni, (in_valid_i && in_ready_o) ##1 (in_valid_i && in_ready_o) ##1 (in_valid_i && in_ready_o), !in_ready_o, "queue took more than its depth")

  // no result is shown as reset is released
  `WSDP_ASSERT_IMPL(a_out_after_reset, clk_i, rst_ni, $rose(rst_ni), !out_valid_o, "result right after reset")

  // while reset is held, the output is not valid and the input is ready
  `WSDP_ASSERT_ALWAYS(a_reset_state, clk_i, (!rst_ni) ##1 (!rst_ni), !out_valid_o && in_ready_o, "reset state not idle")

endmodule

bind weighted_stretched_dot_product wsdp_checker u_wsdp_checker (.*);

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

module tb;

  localparam int unsigned DEPTH_W = 13;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SINK_HOLD_CYCLES = 3000;
  // boundary norm numerators over 48, nearest boundary point first
  localparam logic [27:0] NORM_NUMS = {7'd49, 7'd43, 7'd59, 7'd17};

  typedef struct {
    logic signed [wsdp_pkg::VecW-1:0] u_x;
    logic signed [wsdp_pkg::VecW-1:0] u_y;
    logic signed [wsdp_pkg::VecW-1:0] u_z;
    logic signed [wsdp_pkg::VecW-1:0] v_x;
    logic signed [wsdp_pkg::VecW-1:0] v_y;
    logic signed [wsdp_pkg::VecW-1:0] v_z;
    logic [wsdp_pkg::StrW-1:0]        stretch_x;
    logic [wsdp_pkg::StrW-1:0]        stretch_y;
    logic [wsdp_pkg::StrW-1:0]        stretch_z;
    logic [DEPTH_W-1:0]               depth;
    logic                             last;
  } grid_point_t;

  typedef struct {
    logic [wsdp_pkg::SumW-1:0] sum;
    logic                      sat;
  } domain_sum_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  wsdp_pkg::cfg_idx_e               cfg_idx_i = wsdp_pkg::CFG_DEPTH_LAST;
  logic [DEPTH_W-1:0]               cfg_data_i = '0;
  logic                             in_valid_i = 1'b0;
  logic                             in_ready_o;
  logic signed [wsdp_pkg::VecW-1:0] u_x_i = '0;
  logic signed [wsdp_pkg::VecW-1:0] u_y_i = '0;
  logic signed [wsdp_pkg::VecW-1:0] u_z_i = '0;
  logic signed [wsdp_pkg::VecW-1:0] v_x_i = '0;
  logic signed [wsdp_pkg::VecW-1:0] v_y_i = '0;
  logic signed [wsdp_pkg::VecW-1:0] v_z_i = '0;
  logic [wsdp_pkg::StrW-1:0]        stretch_x_i = '0;
  logic [wsdp_pkg::StrW-1:0]        stretch_y_i = '0;
  logic [wsdp_pkg::StrW-1:0]        stretch_z_i = '0;
  logic [DEPTH_W-1:0]               depth_index_i = '0;
  logic                             last_point_i = 1'b0;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  logic signed [wsdp_pkg::SumW-1:0] weighted_sum_o;
  logic                             saturated_o;

  weighted_stretched_dot_product DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .u_x_i          (u_x_i),
    .u_y_i          (u_y_i),
    .u_z_i          (u_z_i),
    .v_x_i          (v_x_i),
    .v_y_i          (v_y_i),
    .v_z_i          (v_z_i),
    .stretch_x_i    (stretch_x_i),
    .stretch_y_i    (stretch_y_i),
    .stretch_z_i    (stretch_z_i),
    .depth_index_i  (depth_index_i),
    .last_point_i   (last_point_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .weighted_sum_o (weighted_sum_o),
    .saturated_o    (saturated_o)
  );

  // predictor copy of registers and accumulator
  logic [DEPTH_W-1:0]        cfg_depth_last = DEPTH_W'(4096);
  logic [1:0]                cfg_bnd_en = 2'b00;
  logic [wsdp_pkg::SumW-1:0] acc_sum = '0;
  logic                      acc_sat = 1'b0;

  grid_point_t point_queue[$];
  domain_sum_t expected_sums[$];
  grid_point_t offered;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 30;
  int unsigned sink_idle_pct = 30;
  int unsigned src_gap = 0;
  int unsigned sink_stall = 0;
  int unsigned sink_hold_cnt = 0;
  logic        src_taken = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [6:0] norm_weight_for(logic [DEPTH_W-1:0] k);
    logic [6:0] w;
    int unsigned span;
    w = 7'd48;
    if (cfg_bnd_en[0] && k >= 1 && k <= 4) w = NORM_NUMS[7*(k-1) +: 7];
    if (cfg_bnd_en[1] && k <= cfg_depth_last) begin
      span = 32'(cfg_depth_last - k);
      if (span < 4) w = NORM_NUMS[7*span +: 7];
    end
    return w;
  endfunction

  // add one point's weighted term to the running sum, emit on the last point
  function automatic void accumulate_point(grid_point_t p);
    logic signed [127:0] dot;
    logic [127:0]        mag128, num, quo;
    logic [63:0]         mag, den, term, s;
    logic [6:0]          w;
    logic                neg;
    domain_sum_t         res;
    dot = p.u_x * p.v_x + p.u_y * p.v_y + p.u_z * p.v_z;
    neg = dot[127];
    mag128 = neg ? -dot : dot;
    mag = mag128[63:0];
    w = norm_weight_for(p.depth);
    den = 64'(p.stretch_x) * 64'(p.stretch_y) * 64'(p.stretch_z) * 64'd48;
    if (mag == 0) begin
      term = '0;
    end else if (den == 0) begin
      term = neg ? wsdp_pkg::SumMin : wsdp_pkg::SumMax;
      acc_sat = 1'b1;
    end else begin
      num = 128'(mag) * 128'(w);
      num = num << wsdp_pkg::FracShift;
      quo = num / {64'd0, den};
      if (neg) begin
        if (quo > 128'h8000_0000_0000_0000) begin
          term = wsdp_pkg::SumMin;
          acc_sat = 1'b1;
        end else begin
          term = -quo[63:0];
        end
      end else begin
        if (quo > 128'h7FFF_FFFF_FFFF_FFFF) begin
          term = wsdp_pkg::SumMax;
          acc_sat = 1'b1;
        end else begin
          term = quo[63:0];
        end
      end
    end
    s = acc_sum + term;
    if (acc_sum[63] == term[63] && s[63] != acc_sum[63]) begin
      s = acc_sum[63] ? wsdp_pkg::SumMin : wsdp_pkg::SumMax;
      acc_sat = 1'b1;
    end
    acc_sum = s;
    if (p.last) begin
      res.sum = acc_sum;
      res.sat = acc_sat;
      expected_sums.push_back(res);
      acc_sum = '0;
      acc_sat = 1'b0;
    end
  endfunction

  function automatic int unsigned pick_gap(int unsigned pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // input side: drive at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || src_taken) begin
      if (src_gap != 0) begin
        src_gap--;
        in_valid_i <= 1'b0;
      end else if (point_queue.size() != 0) begin
        offered = point_queue.pop_front();
        u_x_i         <= offered.u_x;
        u_y_i         <= offered.u_y;
        u_z_i         <= offered.u_z;
        v_x_i         <= offered.v_x;
        v_y_i         <= offered.v_y;
        v_z_i         <= offered.v_z;
        stretch_x_i   <= offered.stretch_x;
        stretch_y_i   <= offered.stretch_y;
        stretch_z_i   <= offered.stretch_z;
        depth_index_i <= offered.depth;
        last_point_i  <= offered.last;
        in_valid_i    <= 1'b1;
        src_gap = pick_gap(src_idle_pct);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // input transfer: predict at the rising edge
  always @(posedge clk_i) begin
    src_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) accumulate_point(offered);
  end

  // output side: stalls and the long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (sink_hold_cnt != 0) begin
      sink_hold_cnt--;
      out_ready_i <= 1'b0;
    end else if (sink_stall != 0) begin
      sink_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      sink_stall = pick_gap(sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_sums
    domain_sum_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_sums.size() == 0) begin
        $error("unexpected sum transfer: weighted_sum %h saturated %b",
               weighted_sum_o, saturated_o);
        mismatch_count++;
      end else begin
        want = expected_sums.pop_front();
        if (weighted_sum_o !== want.sum) begin
          $error("weighted_sum: expected %h, got %h", want.sum, weighted_sum_o);
          mismatch_count++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %b, got %b", want.sat, saturated_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic grid_point_t mk_point(
    logic signed [wsdp_pkg::VecW-1:0] ux, logic signed [wsdp_pkg::VecW-1:0] uy,
    logic signed [wsdp_pkg::VecW-1:0] uz, logic signed [wsdp_pkg::VecW-1:0] vx,
    logic signed [wsdp_pkg::VecW-1:0] vy, logic signed [wsdp_pkg::VecW-1:0] vz,
    logic [wsdp_pkg::StrW-1:0] sx, logic [wsdp_pkg::StrW-1:0] sy,
    logic [wsdp_pkg::StrW-1:0] sz, logic [DEPTH_W-1:0] depth, logic last);
    grid_point_t p;
    p.u_x = ux; p.u_y = uy; p.u_z = uz;
    p.v_x = vx; p.v_y = vy; p.v_z = vz;
    p.stretch_x = sx; p.stretch_y = sy; p.stretch_z = sz;
    p.depth = depth;
    p.last = last;
    return p;
  endfunction

  function automatic logic signed [wsdp_pkg::VecW-1:0] rand_component();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 2097152) - 32'd1048576;
    if (r < 9) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [wsdp_pkg::StrW-1:0] rand_stretch();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r == 0) return '0;
    if (r == 1) return 16'd1;
    if (r == 2) return 16'hFFFF;
    if (r < 13) return wsdp_pkg::StrW'($urandom_range(0, 65535));
    return wsdp_pkg::StrW'($urandom_range(4096, 65535));
  endfunction

  // mostly near the two boundaries of the current domain
  function automatic logic [DEPTH_W-1:0] rand_depth();
    int unsigned r;
    int d;
    r = $urandom_range(0, 9);
    if (r < 3) return DEPTH_W'($urandom_range(1, 6));
    if (r < 6) begin
      d = int'(cfg_depth_last) + 1 - int'($urandom_range(0, 5));
      if (d < 0) d = 0;
      return d[DEPTH_W-1:0];
    end
    if (r < 8) return DEPTH_W'($urandom_range(1, cfg_depth_last));
    return DEPTH_W'($urandom_range(0, 8191));
  endfunction

  function automatic grid_point_t rand_point(logic last);
    return mk_point(rand_component(), rand_component(), rand_component(),
                    rand_component(), rand_component(), rand_component(),
                    rand_stretch(), rand_stretch(), rand_stretch(), rand_depth(), last);
  endfunction

  task automatic write_reg(input wsdp_pkg::cfg_idx_e idx, input logic [DEPTH_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      wsdp_pkg::CFG_DEPTH_LAST:  cfg_depth_last = value;
      wsdp_pkg::CFG_BOUNDARY_EN: cfg_bnd_en = value[1:0];
      default: ;
    endcase
  endtask

  // all points in, all sums out, then let trailing points finish
  task automatic wait_drained();
    while (point_queue.size() != 0 || in_valid_i || expected_sums.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_domains(input logic [DEPTH_W-1:0] depth_last, input logic [1:0] bnd,
                             input int unsigned n_points, input int unsigned src_pct,
                             input int unsigned sink_pct);
    int unsigned sent;
    int unsigned len;
    write_reg(wsdp_pkg::CFG_DEPTH_LAST, depth_last);
    write_reg(wsdp_pkg::CFG_BOUNDARY_EN, DEPTH_W'(bnd));
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    @(posedge clk_i);
    sent = 0;
    while (sent < n_points) begin
      len = $urandom_range(1, 16);
      if (len > n_points - sent) len = n_points - sent;
      for (int unsigned i = 0; i < len; i++) point_queue.push_back(rand_point(i == len - 1));
      sent += len;
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // reset settings: no boundary weights, depth_last at 4096
    point_queue.push_back(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   16'd1, 16'd1, 16'd1, 13'd1, 1'b1));
    point_queue.push_back(mk_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   16'hFFFF, 16'hFFFF, 16'hFFFF, 13'd4096, 1'b1));
    point_queue.push_back(mk_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   16'hFFFF, 16'hFFFF, 16'hFFFF, 13'd2, 1'b1));
    // zero dot with zero stretching: no flag
    point_queue.push_back(mk_point(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h1, 32'h8000_0000,
                                   16'd0, 16'd0, 16'd0, 13'd3, 1'b1));
    // zero stretching with nonzero dot saturates toward its sign
    point_queue.push_back(mk_point(32'd1, 32'h0, 32'h0, -32'sd1, 32'h0, 32'h0,
                                   16'd16384, 16'd16384, 16'd0, 13'd5, 1'b1));
    point_queue.push_back(mk_point(32'd1, 32'h0, 32'h0, 32'd1, 32'h0, 32'h0,
                                   16'd16384, 16'd0, 16'd16384, 13'd5, 1'b0));
    point_queue.push_back(mk_point(-32'sd65536, 32'h0, 32'h0, 32'd65536, 32'h0, 32'h0,
                                   16'd16384, 16'd16384, 16'd16384, 13'd6, 1'b1));
    // depth outside the domain on both sides
    point_queue.push_back(mk_point(32'd65536, 32'd65536, 32'd65536, 32'd65536, 32'd65536,
                                   32'd65536, 16'd16384, 16'd16384, 16'd16384, 13'd0, 1'b0));
    point_queue.push_back(mk_point(32'd65536, 32'd65536, 32'd65536, 32'd65536, 32'd65536,
                                   32'd65536, 16'd16384, 16'd16384, 16'd16384, 13'd8191, 1'b1));
    // running sum driven past its negative limit
    point_queue.push_back(mk_point(32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0,
                                   16'd16384, 16'd16384, 16'd8192, 13'd7, 1'b0));
    point_queue.push_back(mk_point(32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0,
                                   16'd16384, 16'd16384, 16'd8192, 13'd7, 1'b1));
    wait_drained();

    // short domain: low and high weights overlap, high side wins
    write_reg(wsdp_pkg::CFG_DEPTH_LAST, 13'd6);
    write_reg(wsdp_pkg::CFG_BOUNDARY_EN, 13'd3);
    @(posedge clk_i);
    for (int unsigned k = 0; k < 8; k++)
      point_queue.push_back(mk_point(32'd65536, 32'd131072, -32'sd65536,
                                     32'd65536, 32'd65536, 32'd65536,
                                     16'd16384, 16'd16384, 16'd16384, DEPTH_W'(k), 1'b1));
    wait_drained();

    // full-depth domain, high side
    write_reg(wsdp_pkg::CFG_DEPTH_LAST, 13'd4096);
    @(posedge clk_i);
    for (int unsigned k = 4093; k <= 4097; k++)
      point_queue.push_back(mk_point(32'd65536, 32'd131072, -32'sd65536,
                                     32'd65536, 32'd65536, 32'd65536,
                                     16'd16384, 16'd16384, 16'd16384, DEPTH_W'(k), 1'b1));
    wait_drained();

    // receiver holds off while single-point domains keep coming
    @(posedge clk_i);
    sink_hold_cnt = SINK_HOLD_CYCLES;
    for (int unsigned i = 0; i < 12; i++) point_queue.push_back(rand_point(1'b1));
    wait_drained();

    run_domains(13'd1,    2'd3, 120, 30, 30);
    run_domains(13'd4096, 2'd3, 140, 30, 30);
    run_domains(13'd8,    2'd1, 120, 0,  0);
    run_domains(13'd8,    2'd2, 120, 60, 60);
    run_domains(13'd100,  2'd3, 150, 30, 30);
    run_domains(13'd5,    2'd0, 150, 30, 30);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
